>>> hw/rtl/brp_pkg.sv
package brp_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W = 8;
    localparam int COL_W = 13;
    localparam int ROW_W = 12;
    localparam int PLANE_OUT_W = 3;
    localparam int STATUS_W = 2;
    localparam int CFG_W = 14;
    localparam int ADDR_W = 2;

    localparam int ROW_BYTES_W = 14;
    localparam int IMAGE_ROWS_W = 13;
    localparam int PLANE_COUNT_W = 4;
    localparam int MODE_W = 8;

    localparam int DEF_MAX_ROW_BYTES = 8192;
    localparam int DEF_MAX_ROWS = 4096;
    localparam int DEF_MAX_PLANES = 8;

    localparam logic [ROW_BYTES_W-1:0] RST_ROW_BYTES = 14'd40;
    localparam logic [IMAGE_ROWS_W-1:0] RST_IMAGE_ROWS = 13'd200;
    localparam logic [PLANE_COUNT_W-1:0] RST_PLANE_COUNT = 4'd5;
    localparam logic [MODE_W-1:0] RST_MODE = 8'd1;

    // configuration register indexes
    localparam logic [ADDR_W-1:0] REG_ROW_BYTES = 2'd0;
    localparam logic [ADDR_W-1:0] REG_IMAGE_ROWS = 2'd1;
    localparam logic [ADDR_W-1:0] REG_PLANE_COUNT = 2'd2;
    localparam logic [ADDR_W-1:0] REG_MODE = 2'd3;

    localparam logic [MODE_W-1:0] MODE_NONE = 8'd0;
    localparam logic [MODE_W-1:0] MODE_BYTERUN1 = 8'd1;

    localparam logic [BYTE_W-1:0] CTRL_NOP = 8'h80;

    localparam logic [STATUS_W-1:0] ST_RUN = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LAST = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DECODE_ERR = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MODE_ERR = 2'd3;

    typedef struct packed {
        logic              adv;
        logic              rearm;
        logic [LEN_W-1:0]  len;
    } pos_cmd_t;

    typedef struct packed {
        logic done;
        logic overflow;
    } pos_stat_t;

    typedef struct packed {
        logic [COL_W-1:0]       col;
        logic [PLANE_OUT_W-1:0] plane;
        logic [ROW_W-1:0]       row;
    } pos_view_t;

    typedef struct packed {
        logic                   valid;
        logic [BYTE_W-1:0]      value;
        logic [LEN_W-1:0]       length;
        logic [PLANE_OUT_W-1:0] plane;
        logic [ROW_W-1:0]       row;
        logic [COL_W-1:0]       col;
        logic [STATUS_W-1:0]    status;
    } result_t;

endpackage

>>> hw/rtl/brp_pos.sv
module brp_pos
    import brp_pkg::*;
#(
    parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_PLANES = DEF_MAX_PLANES
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     fire,
    input  pos_cmd_t                 cmd,
    input  logic [ROW_BYTES_W-1:0]   row_bytes,
    input  logic [IMAGE_ROWS_W-1:0]  image_rows,
    input  logic [PLANE_COUNT_W-1:0] plane_count,
    output pos_stat_t                stat,
    output pos_view_t                cur,
    output pos_view_t                nxt
);

    localparam int RB_W = $clog2(MAX_ROW_BYTES + 1);
    localparam int CW = (RB_W > ROW_BYTES_W) ? RB_W : ROW_BYTES_W;
    localparam int IR_W = $clog2(MAX_ROWS + 1);
    localparam int RW = (IR_W > IMAGE_ROWS_W) ? IR_W : IMAGE_ROWS_W;
    localparam int PL_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int PW = ((PL_W + 1) > PLANE_COUNT_W) ? (PL_W + 1) : PLANE_COUNT_W;

    logic [COL_W-1:0] col_reg, col_next;
    logic [PL_W-1:0]  plane_reg, plane_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [CW-1:0]    rb_ext, rb, sum;
    logic [RW-1:0]    ir_ext, ir, r1;
    logic [PW-1:0]    pc_ext, pc, pl1, plane_cur_w, plane_nxt_w;
    logic [COL_W-1:0] step_col;
    logic [PL_W-1:0]  step_plane;
    logic [ROW_W-1:0] step_row;
    logic             done;

    // clamp the registers into their supported ranges
    always_comb
    begin
        rb_ext = CW'(row_bytes);
        if (rb_ext == '0)
            rb = CW'(1);
        else if (rb_ext > CW'(MAX_ROW_BYTES))
            rb = CW'(MAX_ROW_BYTES);
        else
            rb = rb_ext;

        ir_ext = RW'(image_rows);
        if (ir_ext == '0)
            ir = RW'(1);
        else if (ir_ext > RW'(MAX_ROWS))
            ir = RW'(MAX_ROWS);
        else
            ir = ir_ext;

        pc_ext = PW'(plane_count);
        if (pc_ext == '0)
            pc = PW'(1);
        else if (pc_ext > PW'(MAX_PLANES))
            pc = PW'(MAX_PLANES);
        else
            pc = pc_ext;
    end

    always_comb
    begin
        sum = CW'(col_reg) + CW'(cmd.len);
        pl1 = PW'(plane_reg) + PW'(1);
        r1 = RW'(row_reg) + RW'(1);
        step_col = sum[COL_W-1:0];
        step_plane = plane_reg;
        step_row = row_reg;
        done = 1'b0;
        if (sum >= rb)
        begin
            step_col = '0;
            if (pl1 >= pc)
            begin
                step_plane = '0;
                if (r1 >= ir)
                begin
                    step_row = '0;
                    done = 1'b1;
                end
                else
                begin
                    step_row = r1[ROW_W-1:0];
                end
            end
            else
            begin
                step_plane = pl1[PL_W-1:0];
            end
        end
        stat.done = done;
        // run would pass the end of the plane row
        stat.overflow = (sum > rb);
    end

    always_comb
    begin
        col_next = col_reg;
        plane_next = plane_reg;
        row_next = row_reg;
        if (cmd.adv)
        begin
            col_next = step_col;
            plane_next = step_plane;
            row_next = step_row;
        end
        plane_cur_w = PW'(plane_reg);
        plane_nxt_w = PW'(plane_next);
        cur.col = col_reg;
        cur.plane = plane_cur_w[PLANE_OUT_W-1:0];
        cur.row = row_reg;
        nxt.col = col_next;
        nxt.plane = plane_nxt_w[PLANE_OUT_W-1:0];
        nxt.row = row_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            plane_reg <= '0;
            row_reg <= '0;
        end
        else if (fire)
        begin
            if (cmd.rearm)
            begin
                col_reg <= '0;
                plane_reg <= '0;
                row_reg <= '0;
            end
            else
            begin
                col_reg <= col_next;
                plane_reg <= plane_next;
                row_reg <= row_next;
            end
        end
    end

endmodule

>>> hw/rtl/brp_dec.sv
module brp_dec
    import brp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [BYTE_W-1:0] stream_byte,
    input  logic              stream_end,
    input  logic [MODE_W-1:0] compression_mode,
    input  pos_stat_t         stat,
    input  pos_view_t         cur,
    input  pos_view_t         nxt,
    output pos_cmd_t          cmd,
    output result_t           res
);

    localparam logic [1:0] PH_CONTROL = 2'd0;
    localparam logic [1:0] PH_LITERAL = 2'd1;
    localparam logic [1:0] PH_REPEAT = 2'd2;

    localparam logic [1:0] HALT_NONE = 2'd0;
    localparam logic [1:0] HALT_DONE = 2'd1;
    localparam logic [1:0] HALT_ERROR = 2'd2;

    logic [1:0]       phase_reg, phase_next;
    logic [LEN_W-1:0] run_left_reg, run_left_next;
    logic [1:0]       halted_reg, halted_next;

    logic             run_emit;
    logic [LEN_W-1:0] lit_cnt, rep_cnt, left_dec;

    // position command; depends only on the byte, end flag, mode and decode state
    always_comb
    begin
        cmd = '0;
        run_emit = 1'b0;
        lit_cnt = stream_byte + LEN_W'(1);
        // 257 - b, taken mod 256; always 2..128 for a repeat control
        rep_cnt = LEN_W'(1) - stream_byte;

        if (halted_reg == HALT_NONE && compression_mode <= MODE_BYTERUN1)
        begin
            if (compression_mode == MODE_NONE || phase_reg == PH_LITERAL)
            begin
                run_emit = 1'b1;
                cmd.len = LEN_W'(1);
            end
            else if (phase_reg == PH_REPEAT)
            begin
                run_emit = 1'b1;
                cmd.len = run_left_reg;
            end
            else if (stream_byte != CTRL_NOP)
            begin
                cmd.len = stream_byte[BYTE_W-1] ? rep_cnt : lit_cnt;
            end
        end
        cmd.adv = run_emit;
        cmd.rearm = stream_end;
    end

    always_comb
    begin
        phase_next = phase_reg;
        run_left_next = run_left_reg;
        halted_next = halted_reg;
        res = '0;
        left_dec = (run_left_reg == '0) ? '0 : run_left_reg - LEN_W'(1);

        if (halted_reg == HALT_NONE)
        begin
            if (compression_mode > MODE_BYTERUN1)
            begin
                res.valid = 1'b1;
                res.status = ST_MODE_ERR;
                res.plane = cur.plane;
                res.row = cur.row;
                res.col = cur.col;
                halted_next = HALT_ERROR;
            end
            else if (compression_mode != MODE_NONE)
            begin
                if (phase_reg == PH_LITERAL)
                begin
                    run_left_next = left_dec;
                    if (left_dec == '0)
                        phase_next = PH_CONTROL;
                end
                else if (phase_reg == PH_REPEAT)
                begin
                    run_left_next = '0;
                    phase_next = PH_CONTROL;
                end
                else if (stream_byte != CTRL_NOP)
                begin
                    if (stat.overflow)
                    begin
                        res.valid = 1'b1;
                        res.status = ST_DECODE_ERR;
                        res.plane = cur.plane;
                        res.row = cur.row;
                        res.col = cur.col;
                        halted_next = HALT_ERROR;
                    end
                    else
                    begin
                        run_left_next = cmd.len;
                        phase_next = stream_byte[BYTE_W-1] ? PH_REPEAT : PH_LITERAL;
                    end
                end
            end
        end

        if (run_emit)
        begin
            res.valid = 1'b1;
            res.value = stream_byte;
            res.length = cmd.len;
            res.status = stat.done ? ST_LAST : ST_RUN;
            res.plane = cur.plane;
            res.row = cur.row;
            res.col = cur.col;
            if (stat.done)
                halted_next = HALT_DONE;
        end

        // early end: replaces a non-last run, reports the position after this byte
        if (stream_end)
        begin
            if (halted_next == HALT_NONE)
            begin
                res.valid = 1'b1;
                res.value = '0;
                res.length = '0;
                res.status = ST_DECODE_ERR;
                res.plane = nxt.plane;
                res.row = nxt.row;
                res.col = nxt.col;
            end
            phase_next = PH_CONTROL;
            run_left_next = '0;
            halted_next = HALT_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CONTROL;
            run_left_reg <= '0;
            halted_reg <= HALT_NONE;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            run_left_reg <= run_left_next;
            halted_reg <= halted_next;
        end
    end

endmodule

>>> hw/rtl/byterun1_planar_unpacker.sv
// Data path: an accepted byte sits in the input register, is decoded, and its
// result, if any, lands in the result register that drives out_valid.
// Throughput: one byte per cycle while out_stall is low; a result held by
// out_stall stalls the input once the input register is full.
// Reset (rst_n, async, active low) clears the decode position and state,
// empties both registers and loads the configuration defaults.
module byterun1_planar_unpacker
    import brp_pkg::*;
#(
    parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_PLANES = DEF_MAX_PLANES
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_wr_en,
    input  logic [ADDR_W-1:0]      cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wdata,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [BYTE_W-1:0]      stream_byte,
    input  logic                   stream_end,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [BYTE_W-1:0]      run_value,
    output logic [LEN_W-1:0]       run_length,
    output logic [PLANE_OUT_W-1:0] plane_index,
    output logic [ROW_W-1:0]       row_index,
    output logic [COL_W-1:0]       column_start,
    output logic [STATUS_W-1:0]    status
);

    logic [ROW_BYTES_W-1:0]   row_bytes_reg;
    logic [IMAGE_ROWS_W-1:0]  image_rows_reg;
    logic [PLANE_COUNT_W-1:0] plane_count_reg;
    logic [MODE_W-1:0]        mode_reg;

    logic                     s1_valid_reg;
    logic [BYTE_W-1:0]        s1_byte_reg;
    logic                     s1_end_reg;

    logic                     out_valid_reg;
    result_t                  out_reg;

    logic                     adv, fire;
    pos_cmd_t                 cmd;
    pos_stat_t                stat;
    pos_view_t                cur, nxt;
    result_t                  res;

    assign adv = !out_valid_reg || !out_stall;
    assign fire = s1_valid_reg && adv;
    assign in_stall = s1_valid_reg && !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= RST_ROW_BYTES;
            image_rows_reg <= RST_IMAGE_ROWS;
            plane_count_reg <= RST_PLANE_COUNT;
            mode_reg <= RST_MODE;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_ROW_BYTES:   row_bytes_reg <= cfg_wdata[ROW_BYTES_W-1:0];
                REG_IMAGE_ROWS:  image_rows_reg <= cfg_wdata[IMAGE_ROWS_W-1:0];
                REG_PLANE_COUNT: plane_count_reg <= cfg_wdata[PLANE_COUNT_W-1:0];
                REG_MODE:        mode_reg <= cfg_wdata[MODE_W-1:0];
                default:         ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= stream_byte;
            s1_end_reg <= stream_end;
        end
    end

    brp_pos #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_ROWS      (MAX_ROWS),
        .MAX_PLANES    (MAX_PLANES)
    ) u_pos (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .cmd         (cmd),
        .row_bytes   (row_bytes_reg),
        .image_rows  (image_rows_reg),
        .plane_count (plane_count_reg),
        .stat        (stat),
        .cur         (cur),
        .nxt         (nxt)
    );

    brp_dec u_dec (
        .clk              (clk),
        .rst_n            (rst_n),
        .fire             (fire),
        .stream_byte      (s1_byte_reg),
        .stream_end       (s1_end_reg),
        .compression_mode (mode_reg),
        .stat             (stat),
        .cur              (cur),
        .nxt              (nxt),
        .cmd              (cmd),
        .res              (res)
    );

    // result register; a byte with no result just drains the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= fire && res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (fire && res.valid)
            out_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign run_value = out_reg.value;
    assign run_length = out_reg.length;
    assign plane_index = out_reg.plane;
    assign row_index = out_reg.row;
    assign column_start = out_reg.col;
    assign status = out_reg.status;

endmodule
